@@ hw/rtl/mnd_pkg.sv @@
// Shared constants for the Manhattan nearest-distance block.
`default_nettype none
package mnd_pkg;
	// Grid store size defaults
	localparam int MAX_ROWS_DEF = 128;
	localparam int MAX_COLS_DEF = 128;

	// Columns examined per scan step, and the depth of the lane min tree
	localparam int LANES     = 32;
	localparam int LANE_LOG2 = $clog2(LANES);

	// Register map (index = byte address / 4)
	localparam logic [1:0] REG_GRID_ROWS   = 2'd0;
	localparam logic [1:0] REG_GRID_COLS   = 2'd1;
	localparam logic [1:0] REG_MARKER_CHAR = 2'd2;

	localparam logic [7:0] GRID_ROWS_RST   = 8'd128;
	localparam logic [7:0] GRID_COLS_RST   = 8'd128;
	localparam logic [7:0] MARKER_CHAR_RST = 8'd88;

	// Input kinds on the tuser bit
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Result codes
	localparam logic [7:0] NONE_DISTANCE = 8'd255;
	localparam logic [7:0] MAX_DISTANCE  = 8'd254;
endpackage
`default_nettype wire

@@ hw/rtl/mnd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/manhattan_nearest_distance.sv @@
// Top level of the Manhattan nearest-distance block: grid store, scan sequencer, APB registers.
//
//  channel   dir   handshake                  payload
//  s_axis    in    s_axis_tvalid/tready       tdata: row[6:0] col[13:7] cell_char[21:14]
//                                             tuser: func (0 load, 1 query)
//  m_axis    out   m_axis_tvalid/tready       tdata: distance[7:0]; tuser: none_found
//  apb       in    psel/penable/pwrite/pready grid_rows @0x0, grid_cols @0x4, marker_char @0x8
//
// A load beat reads the row, then writes it back with the one bit changed.
// A query walks the active rows one at a time: each row is read from the RAM and captured,
// then rows holding any marked cell are scanned one LANES-wide column chunk at a time,
// and a drain state comes before the result is posted, unless the active area is empty.
// Reset clears per-row valid bits at once, so the grid reads as empty with no clear pass.
// s_axis_tready is high only while idle; a pending result does not block the next beat,
// only the next query completion waits for the output register to drain.
`default_nettype none
module manhattan_nearest_distance #(
	parameter int MAX_ROWS = mnd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mnd_pkg::MAX_COLS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // row[6:0], col[13:7], cell_char[21:14], zero pad
	input  wire logic        s_axis_tuser,  // func
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [7:0]  m_axis_tdata,  // distance[7:0]
	output logic             m_axis_tuser,  // none_found
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CH  = (MAX_COLS + mnd_pkg::LANES - 1) / mnd_pkg::LANES;
	localparam int CHW = (CH > 1) ? $clog2(CH) : 1;
	localparam int PW  = CH * mnd_pkg::LANES;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_Q_RD,
		ST_Q_CAP,
		ST_Q_SCAN,
		ST_Q_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0] grid_rows_q, grid_cols_q, marker_char_q;

	// current beat
	logic [6:0] item_row_q, item_col_q;
	logic       ld_mark_q, ld_ok_q;

	// scan control
	logic [RAW-1:0] scan_row_q;
	logic [CHW-1:0] chunk_q;
	logic [PW-1:0]  row_data_q;
	logic [MAX_ROWS-1:0] row_vld_q;

	// running minimum
	logic [8:0] best_q;
	logic       found_q;

	// output register
	logic       out_vld_q;
	logic [7:0] out_dist_q;
	logic       out_none_q;

	// lane stage
	logic       lane_vld_s1;
	logic [8:0] lane_min_s1;
	logic [7:0] row_diff_s1;

	// RAM
	logic [RAW-1:0]      ram_raddr;
	logic [MAX_COLS-1:0] ram_rdata;
	logic [MAX_COLS-1:0] ram_wdata;
	logic                ram_we;

	// ---------------- APB ----------------
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q   <= mnd_pkg::GRID_ROWS_RST;
			grid_cols_q   <= mnd_pkg::GRID_COLS_RST;
			marker_char_q <= mnd_pkg::MARKER_CHAR_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				mnd_pkg::REG_GRID_ROWS:   grid_rows_q   <= pwdata[7:0];
				mnd_pkg::REG_GRID_COLS:   grid_cols_q   <= pwdata[7:0];
				mnd_pkg::REG_MARKER_CHAR: marker_char_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mnd_pkg::REG_GRID_ROWS:   prdata = {24'd0, grid_rows_q};
			mnd_pkg::REG_GRID_COLS:   prdata = {24'd0, grid_cols_q};
			mnd_pkg::REG_MARKER_CHAR: prdata = {24'd0, marker_char_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// ---------------- active extents ----------------
	logic [8:0] rows_eff, cols_eff;
	assign rows_eff = (9'(grid_rows_q) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(grid_rows_q);
	assign cols_eff = (9'(grid_cols_q) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(grid_cols_q);

	logic [MAX_COLS-1:0] col_mask;
	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = 9'(c) < cols_eff;
		end
	end

	// ---------------- grid store ----------------
	mnd_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (RAW'(item_row_q)),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ram_raddr = (state_q == ST_LD_RD) ? RAW'(item_row_q) : scan_row_q;
	assign ram_we    = (state_q == ST_LD_WR) && ld_ok_q;

	// read-modify-write of one bit; a row never written reads as all clear
	always_comb begin
		ram_wdata = row_vld_q[RAW'(item_row_q)] ? ram_rdata : '0;
		ram_wdata[CW'(item_col_q)] = ld_mark_q;
	end

	// captured row, limited to the active columns
	logic [MAX_COLS-1:0] row_masked;
	assign row_masked = row_vld_q[scan_row_q] ? (ram_rdata & col_mask) : '0;

	logic last_row;
	assign last_row = (9'(scan_row_q) + 9'd1) == rows_eff;

	// ---------------- lane min unit ----------------
	logic [mnd_pkg::LANES-1:0] chunk_bits;
	logic [8:0] lane_val [mnd_pkg::LANES];
	logic [8:0] lane_col, q_col9, q_row9, s_row9;
	logic [8:0] row_diff9;

	assign chunk_bits = row_data_q[chunk_q * mnd_pkg::LANES +: mnd_pkg::LANES];
	assign q_col9     = 9'(item_col_q);
	assign q_row9     = 9'(item_row_q);
	assign s_row9     = 9'(scan_row_q);
	assign row_diff9  = (q_row9 > s_row9) ? (q_row9 - s_row9) : (s_row9 - q_row9);

	// bit 8 set marks an empty lane, so it loses every compare
	always_comb begin
		lane_col = '0;
		for (int j = 0; j < mnd_pkg::LANES; j++) begin
			lane_col = 9'(int'(chunk_q) * mnd_pkg::LANES + j);
			if (chunk_bits[j]) begin
				lane_val[j] = (lane_col > q_col9) ? (lane_col - q_col9) : (q_col9 - lane_col);
			end else begin
				lane_val[j] = 9'h100;
			end
		end
		for (int s = 0; s < mnd_pkg::LANE_LOG2; s++) begin
			for (int i = 0; i < (mnd_pkg::LANES >> (s + 1)); i++) begin
				lane_val[i] = (lane_val[2*i+1] < lane_val[2*i]) ? lane_val[2*i+1] : lane_val[2*i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_vld_s1 <= 1'b0;
		end else begin
			lane_vld_s1 <= (state_q == ST_Q_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		lane_min_s1 <= lane_val[0];
		row_diff_s1 <= row_diff9[7:0];
	end

	logic [8:0] cand_dist;
	assign cand_dist = 9'(row_diff_s1) + 9'(lane_min_s1[7:0]);

	// ---------------- sequencer ----------------
	logic in_acc, out_free;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_vld_q  <= '0;
			scan_row_q <= '0;
			chunk_q    <= '0;
			row_data_q <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			out_vld_q  <= 1'b0;
			out_dist_q <= '0;
			out_none_q <= 1'b0;
			item_row_q <= '0;
			item_col_q <= '0;
			ld_mark_q  <= 1'b0;
			ld_ok_q    <= 1'b0;
		end else begin
			// the posting state refills the output register itself
			if (m_axis_tready && (state_q != ST_DONE)) begin
				out_vld_q <= 1'b0;
			end

			// fold the lane result of the previous scan cycle into the running min
			if (lane_vld_s1 && !lane_min_s1[8] && (!found_q || cand_dist < best_q)) begin
				best_q  <= cand_dist;
				found_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						item_row_q <= s_axis_tdata[6:0];
						item_col_q <= s_axis_tdata[13:7];
						ld_mark_q  <= s_axis_tdata[21:14] == marker_char_q;
						ld_ok_q    <= (9'(s_axis_tdata[6:0]) < 9'(MAX_ROWS)) &&
						              (9'(s_axis_tdata[13:7]) < 9'(MAX_COLS));
						if (s_axis_tuser == mnd_pkg::FUNC_LOAD) begin
							state_q <= ST_LD_RD;
						end else begin
							found_q    <= 1'b0;
							scan_row_q <= '0;
							// an empty active area leaves nothing to scan
							state_q    <= (rows_eff == 9'd0 || cols_eff == 9'd0) ? ST_DONE : ST_Q_RD;
						end
					end
				end
				ST_LD_RD: begin
					state_q <= ST_LD_WR;
				end
				ST_LD_WR: begin
					if (ld_ok_q) begin
						row_vld_q[RAW'(item_row_q)] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_Q_RD: begin
					state_q <= ST_Q_CAP;
				end
				ST_Q_CAP: begin
					if (|row_masked) begin
						row_data_q <= PW'(row_masked);
						chunk_q    <= '0;
						state_q    <= ST_Q_SCAN;
					end else if (last_row) begin
						state_q <= ST_Q_DRAIN;
					end else begin
						scan_row_q <= scan_row_q + RAW'(1);
						state_q    <= ST_Q_RD;
					end
				end
				ST_Q_SCAN: begin
					if (32'(chunk_q) == 32'(CH - 1)) begin
						if (last_row) begin
							state_q <= ST_Q_DRAIN;
						end else begin
							scan_row_q <= scan_row_q + RAW'(1);
							state_q    <= ST_Q_RD;
						end
					end else begin
						chunk_q <= chunk_q + CHW'(1);
					end
				end
				ST_Q_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						if (found_q) begin
							out_dist_q <= (best_q > 9'(mnd_pkg::MAX_DISTANCE)) ?
							              mnd_pkg::MAX_DISTANCE : best_q[7:0];
							out_none_q <= 1'b0;
						end else begin
							out_dist_q <= mnd_pkg::NONE_DISTANCE;
							out_none_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_dist_q;
	assign m_axis_tuser  = out_none_q;
endmodule
`default_nettype wire

@@ hw/rtl/mnd_checker.sv @@
// Port-level checks for the Manhattan nearest-distance block, bound to the top level.
`default_nettype none
module mnd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic        m_axis_tuser
);
	// no-hit flag and the reserved distance code go together
	a_none_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == mnd_pkg::NONE_DISTANCE))
		else $error("none_found without reserved distance");

	a_hit_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata <= mnd_pkg::MAX_DISTANCE))
		else $error("hit distance above saturation limit");

	// every accepted beat takes the sequencer out of idle and drops input ready
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after a beat was taken");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");
endmodule

bind manhattan_nearest_distance mnd_checker u_mnd_checker (.*);
`default_nettype wire

@@ tb/sv/manhattan_nearest_distance_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for manhattan_nearest_distance: grid loads, distance queries, APB setup.

typedef struct packed {
	logic [7:0] distance;
	logic       none_found;
} distance_result_t;

// Tracks the marked grid and the register copy, predicts each query answer.
class mnd_scoreboard;
	bit               marked [mnd_pkg::MAX_ROWS_DEF][mnd_pkg::MAX_COLS_DEF];
	logic [7:0]       rows_cfg;
	logic [7:0]       cols_cfg;
	logic [7:0]       marker_cfg;
	distance_result_t pending_distances[$];
	int               errors;

	function new();
		foreach (marked[r, c])
			marked[r][c] = 1'b0;
		rows_cfg   = mnd_pkg::GRID_ROWS_RST;
		cols_cfg   = mnd_pkg::GRID_COLS_RST;
		marker_cfg = mnd_pkg::MARKER_CHAR_RST;
		errors     = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [7:0] value);
		case (idx)
			mnd_pkg::REG_GRID_ROWS: begin
				rows_cfg = value;
			end
			mnd_pkg::REG_GRID_COLS: begin
				cols_cfg = value;
			end
			mnd_pkg::REG_MARKER_CHAR: begin
				marker_cfg = value;
			end
			default: begin
			end
		endcase
	endfunction

	// Brute-force scan of the active window, clipped to the store size.
	function distance_result_t nearest_distance(int row, int col);
		int               row_lim;
		int               col_lim;
		int               best;
		int               d;
		bit               found;
		distance_result_t res;
		row_lim = (int'(rows_cfg) > mnd_pkg::MAX_ROWS_DEF) ? mnd_pkg::MAX_ROWS_DEF : int'(rows_cfg);
		col_lim = (int'(cols_cfg) > mnd_pkg::MAX_COLS_DEF) ? mnd_pkg::MAX_COLS_DEF : int'(cols_cfg);
		found   = 1'b0;
		best    = 0;
		for (int r = 0; r < row_lim; r++) begin
			for (int c = 0; c < col_lim; c++) begin
				if (marked[r][c]) begin
					d = ((row > r) ? row - r : r - row) + ((col > c) ? col - c : c - col);
					if (!found || d < best) begin
						best  = d;
						found = 1'b1;
					end
				end
			end
		end
		if (found) begin
			res.distance   = (best > int'(mnd_pkg::MAX_DISTANCE)) ? mnd_pkg::MAX_DISTANCE
			                                                     : 8'(best);
			res.none_found = 1'b0;
		end else begin
			res.distance   = mnd_pkg::NONE_DISTANCE;
			res.none_found = 1'b1;
		end
		return res;
	endfunction

	task note_beat(logic func, logic [6:0] row, logic [6:0] col, logic [7:0] ch);
		if (func == mnd_pkg::FUNC_LOAD)
			marked[row][col] = (ch == marker_cfg);
		else
			pending_distances.push_back(nearest_distance(int'(row), int'(col)));
	endtask

	task check_result(logic [7:0] distance, logic none_found);
		distance_result_t want;
		if (pending_distances.size() == 0) begin
			report($sformatf("unexpected result: distance=%0d none_found=%0b",
				distance, none_found));
			return;
		end
		want = pending_distances.pop_front();
		if (distance !== want.distance)
			report($sformatf("distance: got %0d, expected %0d", distance, want.distance));
		if (none_found !== want.none_found)
			report($sformatf("none_found: got %0b, expected %0b", none_found,
				want.none_found));
	endtask

	task report(string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask
endclass

module manhattan_nearest_distance_tb;
	// Watchdog limit; 900+ beats plus stalls stay far below it.
	localparam int         CYCLE_LIMIT   = 5_000_000;
	// Sized to outlast the longest query, used for the final quiet window.
	localparam int         DRAIN_CYCLES  = 1000;
	// Load beats finish through the row read and write-back states; wait this long before reg writes.
	localparam int         LOAD_SETTLE   = 8;
	localparam int         RANDOM_PHASES = 9;
	localparam int         PHASE_BEATS   = 100;
	// Address slot past the three registers; writes there must be ignored.
	localparam logic [1:0] REG_UNUSED    = 2'd3;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;    // row[6:0], col[13:7], cell_char[21:14], pad
	logic        s_axis_tuser  = 1'b0;  // func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;          // distance[7:0]
	logic        m_axis_tuser;          // none_found
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [3:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	// Idle percentages for the sender and the receiver, changed between blocks of phases.
	int send_idle = 0;
	int recv_idle = 0;
	int cycle_count = 0;

	mnd_scoreboard sb = new();

	manhattan_nearest_distance uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Random backpressure on the result side.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Monitors sample pre-edge values, so drive/sample order in a step does not matter.
	// Results are checked before the same edge's input beat is noted; a query can never
	// be answered in the cycle it is accepted, so the order is only for clarity.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_beat(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[13:7],
				s_axis_tdata[21:14]);
	end

	// One input beat. tvalid stays high into the next call when no gap is drawn,
	// so back-to-back beats never lower and raise it in the same step.
	task automatic send_beat(logic func, logic [6:0] row, logic [6:0] col, logic [7:0] ch);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {2'b00, ch, col, row};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Drop tvalid after the last beat of a burst.
	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Block idle: every answer back, input side ready again, last load retired.
	task automatic settle();
		end_burst();
		while (sb.pending_distances.size() != 0)
			@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	// APB write: setup then access. Upper data bits are junk; only [7:0] counts.
	task automatic write_reg(logic [1:0] idx, logic [7:0] value);
		logic [31:0] word;
		word       = $urandom();
		word[7:0]  = value;
		psel      <= 1'b1;
		penable   <= 1'b0;
		pwrite    <= 1'b1;
		paddr     <= {idx, 2'b00};
		pwdata    <= word;
		@(posedge clk);
		penable   <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic configure(logic [7:0] rows, logic [7:0] cols, logic [7:0] marker);
		write_reg(mnd_pkg::REG_GRID_ROWS, rows);
		write_reg(mnd_pkg::REG_GRID_COLS, cols);
		write_reg(mnd_pkg::REG_MARKER_CHAR, marker);
	endtask

	// Sizes: mostly small windows, now and then empty, single, full or oversized.
	function automatic logic [7:0] pick_size();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd128;
			2: return 8'($urandom_range(255, 129));
			3: return 8'd1;
			default: return 8'($urandom_range(32, 1));
		endcase
	endfunction

	// Hand-picked cases: empty grid, corners, farthest distance, overwrite clearing a
	// mark, zero-size windows, oversized rows, marks outside the active window that
	// become visible once it grows, queries from outside the window, extreme chars.
	task automatic directed();
		send_beat(mnd_pkg::FUNC_QUERY, 7'd0, 7'd0, 8'hFF);      // nothing marked yet
		send_beat(mnd_pkg::FUNC_LOAD, 7'd0, 7'd0, mnd_pkg::MARKER_CHAR_RST);
		send_beat(mnd_pkg::FUNC_QUERY, 7'd127, 7'd127, 8'h00);  // farthest corner: 254
		send_beat(mnd_pkg::FUNC_QUERY, 7'd0, 7'd0, 8'h00);
		send_beat(mnd_pkg::FUNC_LOAD, 7'd127, 7'd127, mnd_pkg::MARKER_CHAR_RST);
		send_beat(mnd_pkg::FUNC_QUERY, 7'd64, 7'd64, 8'h00);
		send_beat(mnd_pkg::FUNC_LOAD, 7'd0, 7'd0, 8'hA5);       // overwrite clears the mark
		send_beat(mnd_pkg::FUNC_QUERY, 7'd0, 7'd0, 8'h00);
		send_beat(mnd_pkg::FUNC_LOAD, 7'd127, 7'd0, 8'hFF);
		settle();

		configure(8'd0, 8'd128, mnd_pkg::MARKER_CHAR_RST);      // no rows in use
		write_reg(REG_UNUSED, 8'hFF);
		send_beat(mnd_pkg::FUNC_QUERY, 7'd10, 7'd10, 8'h00);
		settle();

		configure(8'd255, 8'd1, 8'h00);                         // rows clip to store, one col
		send_beat(mnd_pkg::FUNC_LOAD, 7'd3, 7'd0, 8'h00);
		send_beat(mnd_pkg::FUNC_LOAD, 7'd2, 7'd5, 8'h00);       // stored but outside window
		send_beat(mnd_pkg::FUNC_QUERY, 7'd2, 7'd5, 8'h00);      // query outside window
		send_beat(mnd_pkg::FUNC_QUERY, 7'd127, 7'd127, 8'h00);
		settle();

		configure(8'd128, 8'd0, 8'hFF);                         // no cols in use
		send_beat(mnd_pkg::FUNC_QUERY, 7'd1, 7'd1, 8'h00);
		settle();

		configure(8'd128, 8'd128, 8'hFF);
		send_beat(mnd_pkg::FUNC_LOAD, 7'd50, 7'd60, 8'hFF);
		send_beat(mnd_pkg::FUNC_QUERY, 7'd50, 7'd61, 8'h00);
		send_beat(mnd_pkg::FUNC_QUERY, 7'd2, 7'd6, 8'h00);      // earlier hidden mark now seen
		settle();
	endtask

	// Random beat aimed mostly inside the active window so marks land where
	// queries see them; about a fifth go anywhere in the store.
	task automatic random_beat();
		int         row_lim;
		int         col_lim;
		logic [6:0] row;
		logic [6:0] col;
		logic [7:0] ch;
		row_lim = (int'(sb.rows_cfg) > mnd_pkg::MAX_ROWS_DEF || sb.rows_cfg == 0)
		          ? mnd_pkg::MAX_ROWS_DEF : int'(sb.rows_cfg);
		col_lim = (int'(sb.cols_cfg) > mnd_pkg::MAX_COLS_DEF || sb.cols_cfg == 0)
		          ? mnd_pkg::MAX_COLS_DEF : int'(sb.cols_cfg);
		row = ($urandom_range(4) == 0) ? 7'($urandom_range(127))
		                               : 7'($urandom_range(row_lim - 1));
		col = ($urandom_range(4) == 0) ? 7'($urandom_range(127))
		                               : 7'($urandom_range(col_lim - 1));
		if ($urandom_range(99) < 35) begin
			send_beat(mnd_pkg::FUNC_QUERY, row, col, 8'($urandom()));
		end else begin
			// Half the loads carry the marker; the rest mostly clear cells.
			ch = ($urandom_range(1) == 0) ? sb.marker_cfg : 8'($urandom());
			send_beat(mnd_pkg::FUNC_LOAD, row, col, ch);
		end
	endtask

	initial begin
		// First block: sender idles lightly, receiver heavily.
		send_idle = 23;
		recv_idle = 71;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// Swap the idle pattern after a third, drop it for the last third.
			if (phase == RANDOM_PHASES / 3) begin
				send_idle = 71;
				recv_idle = 23;
			end else if (phase == 2 * RANDOM_PHASES / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			settle();
			configure(pick_size(), pick_size(), 8'($urandom()));
			if ($urandom_range(1) == 0)
				write_reg(REG_UNUSED, 8'($urandom()));
			repeat (PHASE_BEATS) random_beat();
		end

		settle();
		// Quiet window: anything arriving now is an extra result.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_distances.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
